// File: src/msi_pkg.sv
// ----------------------------------------------------------------------------
// msi_pkg
// Shared types and constants of the multi-axis step interpolator.
// ----------------------------------------------------------------------------
package msi_pkg;

    localparam int NUM_AXES      = 5;
    localparam int POS_BITS      = 24;
    localparam int DELTA_BITS    = POS_BITS + 1;
    localparam int CMD_BITS      = 2;
    localparam int DELAY_BITS    = 16;
    localparam int CRUISE_BITS   = 20;
    localparam int START_BITS    = 16;
    localparam int DIFF_BITS     = CRUISE_BITS + 2;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam int IN_RAW_BITS   = CMD_BITS + NUM_AXES * POS_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 2 * NUM_AXES + DELAY_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic [START_BITS-1:0]  START_RESET  = START_BITS'(200);
    localparam logic [CRUISE_BITS-1:0] CRUISE_RESET = '0;

    // register index, taken from paddr[2]
    localparam logic REG_CRUISE = 1'b0;
    localparam logic REG_START  = 1'b1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD = 2'd0,
        CMD_TICK = 2'd1,
        CMD_SET  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic load;
        logic tick;
        logic set;
        logic commit;
    } t_lane_ctl;

    typedef struct packed {
        logic [CRUISE_BITS-1:0] cruise;
        logic [START_BITS-1:0]  start;
    } t_cfg;

    typedef struct packed {
        logic                  busy;
        logic                  last;
        logic [DELAY_BITS-1:0] delay;
    } t_ramp_st;

endpackage

// File: src/msi_cfg.sv
// ----------------------------------------------------------------------------
// msi_cfg
// APB register file: cruise delay and start delay.
// ----------------------------------------------------------------------------
module msi_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msi_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [msi_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [msi_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output msi_pkg::t_cfg                     o_cfg
);
    import msi_pkg::*;

    logic [CRUISE_BITS-1:0] r_cruise;
    logic [START_BITS-1:0]  r_start;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= CRUISE_RESET;
            r_start  <= START_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_CRUISE) begin
                r_cruise <= pwdata[CRUISE_BITS-1:0];
            end else begin
                r_start <= pwdata[START_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_CRUISE) begin
            prdata = APB_DATA_BITS'(r_cruise);
        end else begin
            prdata = APB_DATA_BITS'(r_start);
        end
    end

    assign o_cfg.cruise = r_cruise;
    assign o_cfg.start  = r_start;

endmodule

// File: src/msi_lane.sv
// ----------------------------------------------------------------------------
// msi_lane
// One axis: position, pending target, delta magnitude and Bresenham accumulator.
// ----------------------------------------------------------------------------
module msi_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msi_pkg::t_lane_ctl             i_ctl,
    input  logic [msi_pkg::POS_BITS-1:0]   i_target,
    input  logic [msi_pkg::DELTA_BITS-1:0] i_longest,
    output logic [msi_pkg::DELTA_BITS-1:0] o_abs_new,
    output logic                           o_dir_new,
    output logic                           o_dir,
    output logic                           o_step
);
    import msi_pkg::*;

    logic [POS_BITS-1:0]   r_pos;
    logic [POS_BITS-1:0]   r_pend;
    logic [DELTA_BITS-1:0] r_abs;
    logic [DELTA_BITS-1:0] r_acc;
    logic [DELTA_BITS-1:0] n_acc;
    logic                  r_dir;
    logic [DELTA_BITS-1:0] w_delta;
    logic [DELTA_BITS:0]   w_sum;

    assign w_delta   = {i_target[POS_BITS-1], i_target} - {r_pos[POS_BITS-1], r_pos};
    assign o_abs_new = w_delta[DELTA_BITS-1] ? (~w_delta + 1'b1) : w_delta;
    assign o_dir_new = !w_delta[DELTA_BITS-1] && (w_delta != '0);

    assign w_sum = {1'b0, r_acc} + {1'b0, r_abs};

    always_comb begin
        if (w_sum >= {1'b0, i_longest}) begin
            o_step = 1'b1;
            n_acc  = DELTA_BITS'(w_sum - {1'b0, i_longest});
        end else begin
            o_step = 1'b0;
            n_acc  = w_sum[DELTA_BITS-1:0];
        end
    end

    assign o_dir = r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pend <= '0;
            r_abs  <= '0;
            r_acc  <= '0;
            r_dir  <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_pend <= i_target;
                r_abs  <= o_abs_new;
                r_acc  <= '0;
                r_dir  <= o_dir_new;
            end
            if (i_ctl.tick) begin
                r_acc <= n_acc;
            end
            if (i_ctl.set) begin
                r_pos <= i_target;
            end else if (i_ctl.commit) begin
                r_pos <= r_pend;
            end
        end
    end

endmodule

// File: src/msi_ramp.sv
// ----------------------------------------------------------------------------
// msi_ramp
// Move length, iteration count and the linear acceleration delay ramp.
// ----------------------------------------------------------------------------
module msi_ramp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msi_pkg::t_lane_ctl             i_ctl,
    input  msi_pkg::t_cfg                  i_cfg,
    input  logic [msi_pkg::DELTA_BITS-1:0] i_longest_new,
    output logic [msi_pkg::DELTA_BITS-1:0] o_longest,
    output msi_pkg::t_ramp_st              o_st
);
    import msi_pkg::*;

    logic [DELTA_BITS-1:0] r_longest;
    logic [DELTA_BITS-1:0] r_iter;
    logic [DELTA_BITS-1:0] r_accel;
    logic [DELTA_BITS-1:0] r_decel;
    logic [DELAY_BITS-1:0] r_delay;
    logic                  r_busy;

    logic [DIFF_BITS-1:0]  w_diff;
    logic [START_BITS-1:0] w_acc;
    logic [DELTA_BITS-1:0] w_half;
    logic [DELTA_BITS-1:0] w_accel;
    logic [DELTA_BITS:0]   w_iter_inc;
    logic                  w_dec;
    logic                  w_inc;
    logic [DELAY_BITS-1:0] n_delay;

    assign w_diff = DIFF_BITS'(i_cfg.start) - DIFF_BITS'(i_cfg.cruise);
    assign w_acc  = w_diff[DIFF_BITS-1] ? '0 : w_diff[START_BITS-1:0];
    assign w_half = i_longest_new >> 1;
    assign w_accel = (DELTA_BITS'(w_acc) > w_half) ? w_half : DELTA_BITS'(w_acc);

    assign w_dec = r_iter < r_accel;
    assign w_inc = r_iter >= r_decel;

    always_comb begin
        unique case ({w_dec, w_inc})
            2'b10:   n_delay = r_delay - 1'b1;
            2'b01:   n_delay = r_delay + 1'b1;
            default: n_delay = r_delay;
        endcase
    end

    assign w_iter_inc = {1'b0, r_iter} + 1'b1;

    assign o_longest  = r_longest;
    assign o_st.busy  = r_busy;
    assign o_st.last  = w_iter_inc >= {1'b0, r_longest};
    assign o_st.delay = n_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_longest <= '0;
            r_iter    <= '0;
            r_accel   <= '0;
            r_decel   <= '0;
            r_delay   <= '0;
            r_busy    <= 1'b0;
        end else if (i_ctl.load) begin
            r_longest <= i_longest_new;
            r_iter    <= '0;
            r_accel   <= w_accel;
            r_decel   <= i_longest_new - w_accel;
            r_delay   <= i_cfg.start;
            r_busy    <= i_longest_new != '0;
        end else if (i_ctl.tick) begin
            r_iter  <= w_iter_inc[DELTA_BITS-1:0];
            r_delay <= n_delay;
            if (o_st.last) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// File: src/multi_axis_step_interpolator_unit.sv
// ----------------------------------------------------------------------------
// multi_axis_step_interpolator_unit
// Five-axis Bresenham step generator with a linear step-delay ramp.
// ----------------------------------------------------------------------------
// Each beat on the input stream is one command (load move, tick, set
// position) and gives exactly one result beat. The block takes one beat per
// clock while the output side accepts; a beat is held in an input register,
// its per-axis add-compare-subtract and ramp update run combinationally, and
// the result lands in an output register when that register is free or being
// read, so a stalled output holds the beat in the input register; throughput
// stays at one beat per cycle while the output side accepts.
// Load computes deltas, direction and ramp limits; ticks return step pulses,
// directions and the delay; the last tick of a move commits the target.
// Commands that do not apply in the current state return status one.
// ----------------------------------------------------------------------------
module multi_axis_step_interpolator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: cmd[1:0], target_x, target_y, target_z, target_e, target_b (24 b each)
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [msi_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // tdata: step_bits[4:0], dir_bits[9:5], delay_us[25:10]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [msi_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // tuser: status
    output logic                              o_m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msi_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [msi_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [msi_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import msi_pkg::*;

    logic                     r_in_valid;
    logic [IN_DATA_BITS-1:0]  r_in_data;
    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                     r_out_last;
    logic                     r_out_user;

    logic                     w_fire;
    t_cmd                     w_cmd;
    t_lane_ctl                w_ctl;
    t_cfg                     w_cfg;
    t_ramp_st                 w_ramp;
    logic [DELTA_BITS-1:0]    w_longest;
    logic [DELTA_BITS-1:0]    w_longest_new;
    logic [DELTA_BITS-1:0]    w_abs_new [NUM_AXES];
    logic [NUM_AXES-1:0]      w_dir_new;
    logic [NUM_AXES-1:0]      w_dir;
    logic [NUM_AXES-1:0]      w_step;

    logic [NUM_AXES-1:0]      n_steps;
    logic [NUM_AXES-1:0]      n_dirs;
    logic [DELAY_BITS-1:0]    n_delay;
    logic                     n_last;
    logic                     n_status;

    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    assign w_cmd = t_cmd'(r_in_data[CMD_BITS-1:0]);

    assign w_ctl.load   = w_fire && (w_cmd == CMD_LOAD) && !w_ramp.busy;
    assign w_ctl.tick   = w_fire && (w_cmd == CMD_TICK) && w_ramp.busy;
    assign w_ctl.set    = w_fire && (w_cmd == CMD_SET) && !w_ramp.busy;
    assign w_ctl.commit = w_ctl.tick && w_ramp.last;

    msi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        msi_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_target  (r_in_data[CMD_BITS + g*POS_BITS +: POS_BITS]),
            .i_longest (w_longest),
            .o_abs_new (w_abs_new[g]),
            .o_dir_new (w_dir_new[g]),
            .o_dir     (w_dir[g]),
            .o_step    (w_step[g])
        );
    end

    always_comb begin
        w_longest_new = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (w_abs_new[i] > w_longest_new) begin
                w_longest_new = w_abs_new[i];
            end
        end
    end

    msi_ramp u_ramp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_cfg         (w_cfg),
        .i_longest_new (w_longest_new),
        .o_longest     (w_longest),
        .o_st          (w_ramp)
    );

    always_comb begin
        n_steps  = '0;
        n_dirs   = '0;
        n_delay  = '0;
        n_last   = 1'b0;
        n_status = 1'b0;
        priority if (w_ctl.load) begin
            n_dirs = w_dir_new;
            n_last = w_longest_new == '0;
        end else if (w_ctl.tick) begin
            n_steps = w_step;
            n_dirs  = w_dir;
            n_delay = w_ramp.delay;
            n_last  = w_ramp.last;
        end else if (w_ctl.set) begin
            n_status = 1'b0;
        end else begin
            n_status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_data <= i_s_axis_tdata;
        end
        if (w_fire) begin
            r_out_data <= OUT_DATA_BITS'({n_delay, n_dirs, n_steps});
            r_out_last <= n_last;
            r_out_user <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_last_tick_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.commit |=> !w_ramp.busy)
        else $error("busy still set after final tick");

    a_ignored_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0 && !o_m_axis_tlast))
        else $error("ignored command carries payload");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_data)))
        else $error("input register lost a pending beat");

    a_load_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.load && w_longest_new == '0) |=> !w_ramp.busy)
        else $error("zero-length move left block busy");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-axis step interpolator unit.
// ----------------------------------------------------------------------------
// A queue of command beats (load move, tick, set position and junk) is built
// phase by phase and streamed into the block. A cycle-free shadow of the
// Bresenham axes and the delay ramp predicts the result of every accepted
// beat. The monitor compares each result beat, field by field, against the
// oldest prediction. Phases change the ramp registers over APB while the
// block is drained, and vary back-pressure on both streams. One phase also
// holds the output stream off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_top;
    import msi_pkg::*;

    localparam logic [CMD_BITS-1:0]      CMD_BAD     = 2'd3;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_CRUISE = {REG_CRUISE, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] ADDR_START  = {REG_START, 2'b00};
    localparam longint POS_MAX  = (longint'(1) <<< (POS_BITS - 1)) - 1;
    localparam longint POS_MIN  = -(longint'(1) <<< (POS_BITS - 1));
    localparam int     IDLE_LIMIT = 5000;
    localparam int     MAX_PRINTS = 40;

    typedef struct packed {
        logic [NUM_AXES-1:0][POS_BITS-1:0] tgt;
        logic [CMD_BITS-1:0]               cmd;
    } t_axis_cmd;

    typedef struct packed {
        logic [NUM_AXES-1:0]   steps;
        logic [NUM_AXES-1:0]   dirs;
        logic [DELAY_BITS-1:0] delay;
        logic                  last;
        logic                  status;
    } t_step_res;

    typedef struct packed {
        logic [NUM_AXES-1:0][POS_BITS-1:0]   pos;
        logic [NUM_AXES-1:0][POS_BITS-1:0]   tgt;
        logic [NUM_AXES-1:0][DELTA_BITS-1:0] mag;
        logic [NUM_AXES-1:0][DELTA_BITS-1:0] err;
        logic [NUM_AXES-1:0]                 dir;
        logic [DELTA_BITS-1:0]               longest;
        logic [DELTA_BITS-1:0]               iter;
        logic [DELTA_BITS-1:0]               accel_end;
        logic [DELTA_BITS:0]                 decel_begin;
        logic [DELAY_BITS-1:0]               delay;
        logic                                busy;
        logic [CRUISE_BITS-1:0]              cruise;
        logic [START_BITS-1:0]               start;
    } t_axes_state;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]   i_s_axis_tdata = '0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata;
    logic                      o_m_axis_tlast;
    logic                      o_m_axis_tuser;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    t_axis_cmd   cmd_q[$];
    t_step_res   step_res_q[$];
    t_axes_state plan_st;
    t_axes_state shadow_st;
    t_axis_cmd   sent_cmd;
    t_step_res   sent_res;
    t_step_res   got_res;
    t_step_res   want_res;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          sink_hold_cycles = 0;
    int          err_count = 0;
    int          idle_cycles = 0;
    int          beats_used = 0;

    multi_axis_step_interpolator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void interp_step(inout t_axes_state st, input t_axis_cmd c,
                                        output t_step_res r);
        longint              t;
        longint              p;
        longint              d;
        longint              ramp;
        logic [DELTA_BITS-1:0] lng;
        logic [DELTA_BITS:0]   sum;
        r = '0;
        if (c.cmd == CMD_LOAD && !st.busy) begin
            lng = '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                t = $signed(c.tgt[i]);
                p = $signed(st.pos[i]);
                d = t - p;
                st.tgt[i] = c.tgt[i];
                st.mag[i] = DELTA_BITS'((d < 0) ? -d : d);
                st.err[i] = '0;
                if (st.mag[i] > lng) lng = st.mag[i];
                r.dirs[i] = (d > 0);
            end
            st.dir = r.dirs;
            st.longest = lng;
            st.iter = '0;
            ramp = longint'(st.start) - longint'(st.cruise);
            if (ramp < 0) ramp = 0;
            if (ramp > longint'(lng >> 1)) ramp = longint'(lng >> 1);
            st.accel_end = DELTA_BITS'(ramp);
            st.decel_begin = lng - st.accel_end;
            st.delay = st.start;
            if (lng == 0) begin
                st.pos = st.tgt;
                r.last = 1'b1;
            end else begin
                st.busy = 1'b1;
            end
        end else if (c.cmd == CMD_TICK && st.busy) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                sum = st.err[i] + st.mag[i];
                if (sum >= st.longest) begin
                    sum = sum - st.longest;
                    r.steps[i] = 1'b1;
                end
                st.err[i] = DELTA_BITS'(sum);
            end
            if (st.iter < st.accel_end) st.delay = st.delay - 1'b1;
            if ({1'b0, st.iter} >= st.decel_begin) st.delay = st.delay + 1'b1;
            r.dirs = st.dir;
            r.delay = st.delay;
            st.iter = st.iter + 1'b1;
            if (st.iter >= st.longest) begin
                st.pos = st.tgt;
                st.busy = 1'b0;
                r.last = 1'b1;
            end
        end else if (c.cmd == CMD_SET && !st.busy) begin
            st.pos = c.tgt;
        end else begin
            r.status = 1'b1;
        end
    endfunction

    function automatic logic [NUM_AXES-1:0][POS_BITS-1:0] axes5(
        input longint a0, input longint a1, input longint a2,
        input longint a3, input longint a4);
        return {POS_BITS'(a4), POS_BITS'(a3), POS_BITS'(a2), POS_BITS'(a1), POS_BITS'(a0)};
    endfunction

    function automatic logic [NUM_AXES-1:0][POS_BITS-1:0] random_axes();
        logic [NUM_AXES-1:0][POS_BITS-1:0] v;
        for (int i = 0; i < NUM_AXES; i++) v[i] = POS_BITS'($urandom);
        return v;
    endfunction

    // targets within +/- span of the planned position, clipped to the field
    function automatic logic [NUM_AXES-1:0][POS_BITS-1:0] nearby_axes(input int span);
        logic [NUM_AXES-1:0][POS_BITS-1:0] v;
        longint t;
        for (int i = 0; i < NUM_AXES; i++) begin
            t = $signed(plan_st.pos[i]);
            if ($urandom_range(3) != 0)
                t = t + longint'($urandom_range(2 * span)) - span;
            if (t > POS_MAX) t = POS_MAX;
            if (t < POS_MIN) t = POS_MIN;
            v[i] = POS_BITS'(t);
        end
        return v;
    endfunction

    function automatic logic [NUM_AXES-1:0][POS_BITS-1:0] edge_axes();
        logic [NUM_AXES-1:0][POS_BITS-1:0] v;
        for (int i = 0; i < NUM_AXES; i++) begin
            case ($urandom_range(2))
                0: v[i] = POS_BITS'(POS_MAX);
                1: v[i] = POS_BITS'(POS_MIN);
                default: v[i] = POS_BITS'($urandom);
            endcase
        end
        return v;
    endfunction

    task automatic push_beat(input logic [CMD_BITS-1:0] cmd,
                             input logic [NUM_AXES-1:0][POS_BITS-1:0] tgt);
        t_axis_cmd c;
        t_step_res r;
        c.cmd = cmd;
        c.tgt = tgt;
        interp_step(plan_st, c, r);
        cmd_q.push_back(c);
        if (!r.status) beats_used++;
    endtask

    // tick the planned move to its end, with stray commands mixed in
    task automatic run_out_move(input int noise_pct);
        logic [CMD_BITS-1:0] junk;
        while (plan_st.busy) begin
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0: junk = CMD_LOAD;
                    1: junk = CMD_SET;
                    default: junk = CMD_BAD;
                endcase
                push_beat(junk, random_axes());
            end
            push_beat(CMD_TICK, random_axes());
        end
    endtask

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS) $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_ramp(input int cruise, input int start);
        apb_write(ADDR_CRUISE, APB_DATA_BITS'(cruise));
        apb_write(ADDR_START, APB_DATA_BITS'(start));
        plan_st.cruise   = CRUISE_BITS'(cruise);
        plan_st.start    = START_BITS'(start);
        shadow_st.cruise = CRUISE_BITS'(cruise);
        shadow_st.start  = START_BITS'(start);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || i_s_axis_tvalid || step_res_q.size() != 0);
    endtask

    task automatic run_phase(input int cruise, input int start, input int src_pct,
                             input int sink_pct, input int hold, input int budget);
        int goal;
        int kind;
        set_ramp(cruise, start);
        @(negedge i_clk);
        src_idle_pct     = src_pct;
        sink_stall_pct   = sink_pct;
        sink_hold_cycles = hold;
        goal = beats_used + budget;
        while (beats_used < goal) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                push_beat(CMD_LOAD, nearby_axes(($urandom_range(19) == 0) ? 300 : 24));
                run_out_move(10);
            end else if (kind < 70) begin
                push_beat(CMD_LOAD, plan_st.pos);
            end else if (kind < 80) begin
                push_beat(CMD_SET, random_axes());
            end else if (kind < 90) begin
                push_beat(CMD_SET, edge_axes());
            end else begin
                push_beat(($urandom_range(1) == 0) ? CMD_TICK : CMD_BAD, random_axes());
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                interp_step(shadow_st, sent_cmd, sent_res);
                step_res_q.push_back(sent_res);
            end
            if (cmd_q.size() == 0 || $urandom_range(99) < src_idle_pct) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                sent_cmd = cmd_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {{(IN_DATA_BITS - IN_RAW_BITS){1'b0}},
                                    sent_cmd.tgt, sent_cmd.cmd};
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_res.steps  = o_m_axis_tdata[NUM_AXES-1:0];
                got_res.dirs   = o_m_axis_tdata[2*NUM_AXES-1:NUM_AXES];
                got_res.delay  = o_m_axis_tdata[2*NUM_AXES+DELAY_BITS-1:2*NUM_AXES];
                got_res.last   = o_m_axis_tlast;
                got_res.status = o_m_axis_tuser;
                if (step_res_q.size() == 0) begin
                    report_error($sformatf("result beat with none pending: %h", got_res));
                end else begin
                    want_res = step_res_q.pop_front();
                    if (got_res.steps !== want_res.steps)
                        report_error($sformatf("step_bits %h, want %h",
                                               got_res.steps, want_res.steps));
                    if (got_res.dirs !== want_res.dirs)
                        report_error($sformatf("dir_bits %h, want %h",
                                               got_res.dirs, want_res.dirs));
                    if (got_res.delay !== want_res.delay)
                        report_error($sformatf("delay_us %0d, want %0d",
                                               got_res.delay, want_res.delay));
                    if (got_res.last !== want_res.last)
                        report_error($sformatf("last %b, want %b",
                                               got_res.last, want_res.last));
                    if (got_res.status !== want_res.status)
                        report_error($sformatf("status %b, want %b",
                                               got_res.status, want_res.status));
                end
            end
            if (sink_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || psel || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        plan_st         = '0;
        plan_st.start   = START_RESET;
        plan_st.cruise  = CRUISE_RESET;
        shadow_st       = plan_st;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray commands, edge positions, zero-length and short moves
        set_ramp(0, 200);
        @(negedge i_clk);
        push_beat(CMD_TICK, random_axes());
        push_beat(CMD_BAD, random_axes());
        push_beat(CMD_SET, axes5(POS_MAX, POS_MIN, 0, -1, 1));
        push_beat(CMD_LOAD, axes5(POS_MAX, POS_MIN, 0, -1, 1));
        push_beat(CMD_LOAD, axes5(POS_MAX - 3, POS_MIN + 5, 0, 1, 0));
        push_beat(CMD_LOAD, random_axes());
        push_beat(CMD_SET, random_axes());
        push_beat(CMD_BAD, random_axes());
        run_out_move(0);
        push_beat(CMD_TICK, random_axes());
        push_beat(CMD_SET, axes5(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN));
        push_beat(CMD_LOAD, axes5(POS_MIN + 4, POS_MIN + 4, POS_MIN + 4, POS_MIN + 4,
                                  POS_MIN + 4));
        run_out_move(0);
        push_beat(CMD_SET, axes5(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        push_beat(CMD_LOAD, axes5(POS_MAX - 6, POS_MAX, POS_MAX - 3, POS_MAX - 2, POS_MAX));
        run_out_move(0);
        wait_drained();

        run_phase(0, 10, 0, 0, 0, 105);
        run_phase(1000000, 65535, 52, 0, 0, 105);
        run_phase(0, 65535, 0, 52, 0, 105);
        run_phase(0, 1, 7, 7, 0, 105);
        run_phase($urandom_range(1000000), $urandom_range(65535, 1), 0, 0, 400, 105);
        run_phase($urandom_range(40), $urandom_range(60, 1), 52, 52, 0, 105);

        repeat (10) @(posedge i_clk);
        if (step_res_q.size() != 0)
            report_error($sformatf("%0d result beats never arrived", step_res_q.size()));
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
src/msi_pkg.sv
src/msi_cfg.sv
src/msi_lane.sv
src/msi_ramp.sv
src/multi_axis_step_interpolator_unit.sv
bench/tb_top.sv
